@@ design/cat_pkg.sv @@
// shared types and constants for the client address table
// no dependencies; every other file of the block refers to this package
package cat_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int ADDR_BITS_DEF = 48;

    localparam int FUNC_W     = 2;
    localparam int ID_W       = 6;
    localparam int IN_ADDR_W  = 48;
    localparam int STATUS_W   = 2;
    localparam int OUT_ADDR_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP = 2'd0,
        FN_GET    = 2'd1,
        FN_ADD    = 2'd2,
        FN_REMOVE = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_we;   // clear one slot during the pass after reset
        logic load;     // capture request, rewind slot counter
        logic rd_en;    // read next slot
        logic finish;   // load result register, commit table update
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last; // last slot being cleared
        logic cnt_end;  // every slot has been read
        logic stop;     // search outcome known
        logic out_free; // result register can take a result
    } t_sts;

endpackage

@@ design/cat_req_if.sv @@
// request channel of the client address table
// depends on cat_pkg for field widths
interface cat_req_if;
    logic                           valid;
    logic                           ready;
    logic [cat_pkg::FUNC_W-1:0]     func;
    logic [cat_pkg::IN_ADDR_W-1:0]  addr;
    logic [cat_pkg::ID_W-1:0]       query_slot;

    modport source (output valid, output func, output addr, output query_slot, input ready);
    modport sink   (input valid, input func, input addr, input query_slot, output ready);
endinterface

@@ design/cat_rsp_if.sv @@
// response channel of the client address table
// depends on cat_pkg for field widths
interface cat_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [cat_pkg::STATUS_W-1:0]    status;
    logic [cat_pkg::ID_W-1:0]        slot_id;
    logic [cat_pkg::OUT_ADDR_W-1:0]  slot_addr;

    modport source (output valid, output status, output slot_id, output slot_addr, input ready);
    modport sink   (input valid, input status, input slot_id, input slot_addr, output ready);
endinterface

@@ design/cat_ctrl.sv @@
// sequencing state machine of the client address table
// depends on cat_pkg (state, command and status types)
module cat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  cat_pkg::t_sts i_sts,
    output cat_pkg::t_cmd o_cmd
);

    cat_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cat_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            cat_pkg::S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = cat_pkg::S_IDLE;
                end
            end
            cat_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = cat_pkg::S_SCAN;
                end
            end
            cat_pkg::S_SCAN: begin
                if (i_sts.stop) begin
                    n_state = cat_pkg::S_DONE;
                end else begin
                    o_cmd.rd_en = !i_sts.cnt_end;
                end
            end
            cat_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = cat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cat_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

@@ design/cat_dpath.sv @@
// slot memory, scan counter, match logic and result register
// depends on cat_pkg (field widths, operation and status codes, command types)
module cat_dpath #(
    parameter int SLOTS     = cat_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = cat_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cat_pkg::t_cmd                     i_cmd,
    output cat_pkg::t_sts                     o_sts,
    input  logic [cat_pkg::FUNC_W-1:0]        i_func,
    input  logic [cat_pkg::IN_ADDR_W-1:0]     i_addr,
    input  logic [cat_pkg::ID_W-1:0]          i_query_slot,
    input  logic                              i_rsp_ready,
    output logic                              o_rsp_valid,
    output logic [cat_pkg::STATUS_W-1:0]      o_status,
    output logic [cat_pkg::ID_W-1:0]          o_slot_id,
    output logic [cat_pkg::OUT_ADDR_W-1:0]    o_slot_addr
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENT_W = ADDR_BITS + 1;

    // entry: valid bit on top, address below
    logic [ENT_W-1:0] r_mem [SLOTS];

    cat_pkg::t_func        r_func;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [cat_pkg::ID_W-1:0] r_id;
    logic [CNT_W-1:0]      r_cnt;
    logic [ENT_W-1:0]      r_rd_data;
    logic [IDX_W-1:0]      r_chk_idx;
    logic                  r_chk_vld;
    logic                  r_out_valid;
    logic [cat_pkg::STATUS_W-1:0]   r_status;
    logic [cat_pkg::ID_W-1:0]       r_slot_id;
    logic [cat_pkg::OUT_ADDR_W-1:0] r_slot_addr;

    logic [IDX_W-1:0]      cnt_idx;
    logic [IDX_W-1:0]      id_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic [ENT_W-1:0]      wr_data;
    logic                  wr_en;
    logic                  ent_valid;
    logic [ADDR_BITS-1:0]  ent_addr;
    logic                  id_in_range;
    logic                  hit;
    logic                  last_chk;
    logic                  is_get;
    logic                  is_add;
    logic                  is_remove;
    logic [ADDR_BITS-1:0]  res_addr;
    cat_pkg::t_status      res_status;

    assign cnt_idx     = r_cnt[IDX_W-1:0];
    assign id_idx      = IDX_W'(r_id);
    assign id_in_range = (32'(r_id) < 32'(SLOTS));
    assign is_get      = (r_func == cat_pkg::FN_GET);
    assign is_add      = (r_func == cat_pkg::FN_ADD);
    assign is_remove   = (r_func == cat_pkg::FN_REMOVE);
    assign rd_idx      = is_get ? id_idx : cnt_idx;
    assign ent_valid   = r_rd_data[ENT_W-1];
    assign ent_addr    = r_rd_data[ADDR_BITS-1:0];
    assign last_chk    = (32'(r_chk_idx) == 32'(SLOTS - 1));

    always_comb begin
        case (r_func)
            cat_pkg::FN_GET: hit = ent_valid && id_in_range;
            cat_pkg::FN_ADD: hit = !ent_valid;
            default:         hit = ent_valid && (ent_addr == r_addr);
        endcase
    end

    assign o_sts.clr_last = (32'(r_cnt) == 32'(SLOTS - 1));
    assign o_sts.cnt_end  = (32'(r_cnt) == 32'(SLOTS));
    assign o_sts.stop     = r_chk_vld && (hit || is_get || last_chk);
    assign o_sts.out_free = !r_out_valid || i_rsp_ready;

    // table update: clearing pass, claim on add, release on remove
    assign wr_en   = i_cmd.clr_we || (i_cmd.finish && hit && (is_add || is_remove));
    assign wr_idx  = i_cmd.clr_we ? cnt_idx : r_chk_idx;
    assign wr_data = i_cmd.clr_we ? '0 : {is_add, (is_add ? r_addr : ent_addr)};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_idx];
            r_chk_idx <= rd_idx;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= cat_pkg::t_func'(i_func);
            r_addr <= ADDR_BITS'(i_addr);
            r_id   <= i_query_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_we || i_cmd.rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // result formation
    assign res_addr   = is_add ? r_addr : ent_addr;
    assign res_status = hit ? cat_pkg::ST_OK : (is_add ? cat_pkg::ST_FULL : cat_pkg::ST_NOT_FOUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status    <= res_status;
            r_slot_id   <= hit ? cat_pkg::ID_W'(r_chk_idx) : '0;
            r_slot_addr <= hit ? cat_pkg::OUT_ADDR_W'(res_addr) : '0;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot_id   = r_slot_id;
    assign o_slot_addr = r_slot_addr;

endmodule

@@ design/client_address_table_core.sv @@
// top level of the client address table: controller, datapath and channel hookup
// depends on cat_pkg, cat_req_if, cat_rsp_if, cat_ctrl and cat_dpath
//
// usage
// - a table of SLOTS client slots, each a valid bit and an ADDR_BITS peer address
// - request channel i_req carries func, addr and query_slot; one response per
//   request leaves on o_rsp with status, slot_id and slot_addr
// - lookup returns the lowest valid slot holding addr; get returns slot
//   query_slot if it is in use; add claims the lowest free slot (duplicates
//   allowed) or reports full; remove frees the lowest valid slot holding addr
// - slots live in one single-port-write, single-port-read memory; the search
//   reads one slot per cycle and checks it the cycle after
// - one request is in flight at a time; the next request is taken once the
//   result loads, so the slot scan sets how long a request occupies the block
// - after reset the block sweeps the memory clearing every valid bit, one
//   slot a cycle, with i_req.ready low
// - the result sits in an output register; a new request is taken while it
//   waits, and its scan runs, but the next result is held until the receiver
//   takes the pending one
module client_address_table_core #(
    parameter int SLOTS     = cat_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = cat_pkg::ADDR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cat_req_if.sink    i_req,
    cat_rsp_if.source  o_rsp
);

    // command and status between the state machine and the datapath
    cat_pkg::t_cmd cmd;
    cat_pkg::t_sts sts;
    logic          req_ready;

    assign i_req.ready = req_ready;

    // sequencing: clearing pass, idle, slot scan, result hand-off
    cat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // slot memory, scan counter, comparison and result register
    cat_dpath #(
        .SLOTS     (SLOTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_req.func),
        .i_addr       (i_req.addr),
        .i_query_slot (i_req.query_slot),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_slot_id    (o_rsp.slot_id),
        .o_slot_addr  (o_rsp.slot_addr)
    );

endmodule
